### design/uule_pkg.sv
// Shared types and constants of the uuencode line encoder.
// Used by the character unit and the top level; depends on nothing.
`default_nettype none

package uule_pkg;

   localparam int BYTE_W = 8;
   localparam int SIX_W  = 6;
   localparam int CHAR_W = 7;

   // Printable offset added to every six-bit value.
   localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'd32;

   // Which character the shared unit produces.
   localparam logic [2:0] CH_LEN  = 3'd0;
   localparam logic [2:0] CH_G0   = 3'd1;
   localparam logic [2:0] CH_G1   = 3'd2;
   localparam logic [2:0] CH_G2   = 3'd3;
   localparam logic [2:0] CH_G3   = 3'd4;
   localparam logic [2:0] CH_TERM = 3'd5;

   typedef struct packed {
      logic [2:0]        mode;
      logic [SIX_W-1:0]  len;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
   } char_req_type;

endpackage

`default_nettype wire

### design/uule_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module uule_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 45,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/uule_char_unit.sv
// Shared character unit: cuts one six-bit value out of the byte group
// (or takes the line length) and adds the printable offset. Uses uule_pkg.
`default_nettype none

module uule_char_unit import uule_pkg::*; (
   input  wire char_req_type       req,
   output logic     [CHAR_W-1:0]   char_out
);

   logic [SIX_W-1:0] six;

   always_comb begin
      case (req.mode)
         CH_LEN:  six = req.len;
         CH_G0:   six = req.b0[7:2];
         CH_G1:   six = {req.b0[1:0], req.b1[7:4]};
         CH_G2:   six = {req.b1[3:0], req.b2[7:6]};
         CH_G3:   six = req.b2[5:0];
         CH_TERM: six = '0;
         default: six = '0;
      endcase
   end

   assign char_out = {1'b0, six} + CHAR_BIAS;

endmodule

`default_nettype wire

### design/uuencode_line_encoder_unit.sv
// uuencode line encoder: gathers bytes into a line store and emits
// uuencoded lines one character per transfer.
// The req channel carries one byte per transfer; req_tuser says whether
// the byte is present, req_tlast closes the input. The rsp channel carries
// one printable character per transfer; rsp_tuser flags the end of a line
// and the terminating zero-length line, rsp_tlast marks the last character
// caused by one req transfer.
// A byte that does not complete a line gives no result.
// A line is emitted as its length character and then, per group of
// three bytes, a fetch of the bytes through the single read port of
// the line store and four characters from the shared character unit.
// The terminating line is a single character. req_tready is low while
// a line is being emitted. If the receiver holds rsp_tready low, the
// character in the output register is held and the sequence waits.
// A synchronous reset empties the line store count and drops rsp_tvalid;
// the store contents need no clearing.
`default_nettype none

module uuencode_line_encoder_unit import uule_pkg::*; #(
   parameter int LINE_BYTES = 45
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tuser,   // [0] byte_present
   input  wire logic       req_tlast,   // end_of_input
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [6:0] text_char, [7] zero
   output logic      [1:0] rsp_tuser,   // [0] end_of_line, [1] end_of_text
   output logic            rsp_tlast    // last
);

   localparam int CntW  = $clog2(LINE_BYTES + 1);
   localparam int AddrW = $clog2(LINE_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LEN   = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_TERM  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [CntW-1:0]   idx_ff, idx_in;
   logic [1:0]        sub_ff, sub_in;
   logic              end_pend_ff, end_pend_in;
   logic              rd_en_ff;
   logic [BYTE_W-1:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_eol_ff, rsp_eot_ff, rsp_last_ff;

   logic              accept;
   logic              out_free;
   logic              emit_go;
   logic              emit_eol, emit_eot, emit_last;
   logic              wr_en, rd_en;
   logic [CntW:0]     rd_sum;
   logic [CntW:0]     grp_end;
   logic              final_group;
   logic [CntW-1:0]   cnt_next;
   logic [BYTE_W-1:0] rd_data;
   logic [BYTE_W-1:0] rd_byte;
   char_req_type      creq;
   logic [CHAR_W-1:0] char_out;

   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid & req_tready;
   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign wr_en       = accept & req_tuser & (count_ff < CntW'(LINE_BYTES));
   assign cnt_next    = wr_en ? count_ff + 1'b1 : count_ff;
   assign rd_sum      = {1'b0, idx_ff} + {{(CntW - 1){1'b0}}, sub_ff};
   assign rd_en       = (state_ff == S_FETCH) && (sub_ff != 2'd3)
                        && (rd_sum < {1'b0, count_ff});
   assign grp_end     = {1'b0, idx_ff} + (CntW + 1)'(3);
   assign final_group = (grp_end >= {1'b0, count_ff});
   // A read past the end of the line stands for a zero pad byte.
   assign rd_byte     = rd_en_ff ? rd_data : '0;

   uule_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(LINE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AddrW-1:0]),
      .wr_data(req_tdata),
      .rd_en  (rd_en),
      .rd_addr(rd_sum[AddrW-1:0]),
      .rd_data(rd_data)
   );

   uule_char_unit u_char (
      .req     (creq),
      .char_out(char_out)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      sub_in      = sub_ff;
      end_pend_in = end_pend_ff;
      b0_in       = b0_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      emit_go     = 1'b0;
      emit_eol    = 1'b0;
      emit_eot    = 1'b0;
      emit_last   = 1'b0;
      creq.mode   = CH_TERM;
      creq.len    = SIX_W'(count_ff);
      creq.b0     = b0_ff;
      creq.b1     = b1_ff;
      creq.b2     = b2_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in    = cnt_next;
               end_pend_in = req_tlast;
               if (req_tuser && cnt_next == CntW'(LINE_BYTES)) begin
                  state_in = S_LEN;
               end else if (req_tlast && cnt_next != '0) begin
                  state_in = S_LEN;
               end else if (req_tlast) begin
                  state_in = S_TERM;
               end
            end
         end
         S_LEN: begin
            creq.mode = CH_LEN;
            emit_eol  = (count_ff == '0);
            if (out_free) begin
               emit_go  = 1'b1;
               idx_in   = '0;
               sub_in   = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // Reads are issued for sub 0..2 and land in the next cycle.
            case (sub_ff)
               2'd1:    b0_in = rd_byte;
               2'd2:    b1_in = rd_byte;
               2'd3:    b2_in = rd_byte;
               default: ;
            endcase
            if (sub_ff == 2'd3) begin
               sub_in   = '0;
               state_in = S_EMIT;
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         S_EMIT: begin
            case (sub_ff)
               2'd0:    creq.mode = CH_G0;
               2'd1:    creq.mode = CH_G1;
               2'd2:    creq.mode = CH_G2;
               default: creq.mode = CH_G3;
            endcase
            emit_eol  = (sub_ff == 2'd3) && final_group;
            emit_last = emit_eol && !end_pend_ff;
            if (out_free) begin
               emit_go = 1'b1;
               if (sub_ff == 2'd3) begin
                  sub_in = '0;
                  if (final_group) begin
                     count_in = '0;
                     state_in = end_pend_ff ? S_TERM : S_IDLE;
                  end else begin
                     idx_in   = grp_end[CntW-1:0];
                     state_in = S_FETCH;
                  end
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end
         end
         S_TERM: begin
            creq.mode = CH_TERM;
            emit_eol  = 1'b1;
            emit_eot  = 1'b1;
            emit_last = 1'b1;
            if (out_free) begin
               emit_go     = 1'b1;
               end_pend_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         sub_ff       <= '0;
         end_pend_ff  <= 1'b0;
         rd_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         sub_ff       <= sub_in;
         end_pend_ff  <= end_pend_in;
         rd_en_ff     <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      if (emit_go) begin
         rsp_char_ff <= char_out;
         rsp_eol_ff  <= emit_eol;
         rsp_eot_ff  <= emit_eot;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tuser  = {rsp_eot_ff, rsp_eol_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
